>>> rtl/stca_pkg.sv
// ============================================================================
// Scroll-to-click accumulator package
// Shared widths, operation codes, register indexes and reset values.
// ============================================================================
package stca_pkg;

    localparam int ACC_WIDTH   = 32;
    localparam int ACC_EXT_W   = ACC_WIDTH + 1;
    localparam int SHAPE_W     = 12;

    localparam int OPCODE_W    = 2;
    localparam int DELTA_W     = 8;
    localparam int ELAPSED_W   = 32;
    localparam int COUNT_W     = 8;
    localparam int HOLD_W      = 16;
    localparam int SHIFT_W     = 5;
    localparam int CURVE_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OPCODE_W-1:0] OP_SCROLL = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIV_SHIFT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PENDING_MAX     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_TO_CLICK = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CURVE_MODE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_RELOAD     = 3'd5;

    localparam logic [CURVE_W-1:0] CURVE_LINEAR    = 3'd0;
    localparam logic [CURVE_W-1:0] CURVE_ONE_HALF  = 3'd1;
    localparam logic [CURVE_W-1:0] CURVE_DOUBLE    = 3'd2;
    localparam logic [CURVE_W-1:0] CURVE_SQUARE    = 3'd3;
    localparam logic [CURVE_W-1:0] CURVE_LIN_SQ    = 3'd4;

    localparam logic [ELAPSED_W-1:0] TICK_MIN_US   = 32'd1000;

    localparam logic [SHIFT_W-1:0] DIV_SHIFT_RST   = 5'd3;
    localparam logic [COUNT_W-1:0] PENDING_MAX_RST = 8'd8;
    localparam logic [HOLD_W-1:0]  HOLD_RELOAD_RST = 16'd10;

endpackage

>>> rtl/scroll_to_click_accumulator_top.sv
// ============================================================================
// Scroll-to-click accumulator
// Shapes wheel deltas into a saturating accumulator, queues whole threshold
// steps as pending clicks and releases them one per expired hold on ticks.
// ============================================================================
// The block takes one transaction per clock cycle while the result side does not
// stall, and presents exactly one result per transaction: the transaction is
// captured in an input register at the accepting edge, and at an edge where the
// result side advances one pass of logic (curve, saturating add, click count by
// shift and minimum, tick handling) updates the state and result registers
// together. Back-pressure on the result side stalls a full input register, so a
// new transaction is taken while one result waits only if that register is empty.
module scroll_to_click_accumulator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [stca_pkg::OPCODE_W-1:0]       s_opcode,
    input  logic signed [stca_pkg::DELTA_W-1:0] s_scroll_delta,
    input  logic [stca_pkg::ELAPSED_W-1:0]      s_elapsed_us,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_click,
    output logic [stca_pkg::COUNT_W-1:0]        m_pending_count,
    output logic [stca_pkg::HOLD_W-1:0]         m_hold_left,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stca_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stca_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import stca_pkg::*;

    logic                   enable_reg;
    logic [SHIFT_W-1:0]     div_shift_reg;
    logic [COUNT_W-1:0]     pending_max_reg;
    logic                   scroll_to_click_reg;
    logic [CURVE_W-1:0]     curve_mode_reg;
    logic [HOLD_W-1:0]      hold_reload_reg;

    logic                   in_valid_reg;
    logic [OPCODE_W-1:0]    in_opcode_reg;
    logic signed [DELTA_W-1:0] in_delta_reg;
    logic [ELAPSED_W-1:0]   in_elapsed_reg;

    logic                   out_valid_reg;
    logic                   out_click_reg;
    logic                   out_click_next;

    logic [ACC_WIDTH-1:0]   acc_reg;
    logic [ACC_WIDTH-1:0]   acc_next;
    logic [COUNT_W-1:0]     pending_reg;
    logic [COUNT_W-1:0]     pending_next;
    logic [HOLD_W-1:0]      hold_reg;
    logic [HOLD_W-1:0]      hold_next;

    logic                   adv;

    logic signed [SHAPE_W-1:0]   v_ext;
    logic signed [2*DELTA_W-1:0] v_sq;
    logic signed [SHAPE_W-1:0]   shaped;
    logic [ACC_EXT_W-1:0]   sum_ext;
    logic [ACC_WIDTH-1:0]   acc_sat;
    logic                   acc_neg;
    logic [ACC_EXT_W-1:0]   acc_sat_ext;
    logic [ACC_EXT_W-1:0]   mag;
    logic [ACC_EXT_W-1:0]   quot;
    logic [COUNT_W-1:0]     room;
    logic [COUNT_W-1:0]     n_clicks;
    logic [ACC_EXT_W-1:0]   step;
    logic [ACC_EXT_W-1:0]   acc_adj;

    assign adv       = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    assign m_valid         = out_valid_reg;
    assign m_click         = out_click_reg;
    assign m_pending_count = pending_reg;
    assign m_hold_left     = hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg          <= 1'b0;
            div_shift_reg       <= DIV_SHIFT_RST;
            pending_max_reg     <= PENDING_MAX_RST;
            scroll_to_click_reg <= 1'b1;
            curve_mode_reg      <= CURVE_LINEAR;
            hold_reload_reg     <= HOLD_RELOAD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ENABLE:          enable_reg          <= cfg_data[0];
                REG_DIV_SHIFT:       div_shift_reg       <= cfg_data[SHIFT_W-1:0];
                REG_PENDING_MAX:     pending_max_reg     <= cfg_data[COUNT_W-1:0];
                REG_SCROLL_TO_CLICK: scroll_to_click_reg <= cfg_data[0];
                REG_CURVE_MODE:      curve_mode_reg      <= cfg_data[CURVE_W-1:0];
                REG_HOLD_RELOAD:     hold_reload_reg     <= cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg  <= s_opcode;
            in_delta_reg   <= s_scroll_delta;
            in_elapsed_reg <= s_elapsed_us;
        end
    end

    always_comb begin
        v_ext = {{(SHAPE_W-DELTA_W){in_delta_reg[DELTA_W-1]}}, in_delta_reg};
        v_sq  = (2*DELTA_W)'(in_delta_reg) * (2*DELTA_W)'(in_delta_reg);
        case (curve_mode_reg)
            CURVE_ONE_HALF: shaped = v_ext + (v_ext >>> 1);
            CURVE_DOUBLE:   shaped = v_ext <<< 1;
            CURVE_SQUARE:   shaped = $signed({1'b0, v_sq[2*DELTA_W-2:4]});
            CURVE_LIN_SQ:   shaped = v_ext + $signed({3'b000, v_sq[2*DELTA_W-2:6]});
            default:        shaped = v_ext;
        endcase
    end

    always_comb begin
        sum_ext = {acc_reg[ACC_WIDTH-1], acc_reg}
                + {{(ACC_EXT_W-SHAPE_W){shaped[SHAPE_W-1]}}, shaped};
        if (sum_ext[ACC_EXT_W-1] != sum_ext[ACC_WIDTH-1]) begin
            acc_sat = sum_ext[ACC_EXT_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                           : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            acc_sat = sum_ext[ACC_WIDTH-1:0];
        end
        acc_neg     = acc_sat[ACC_WIDTH-1];
        acc_sat_ext = {acc_neg, acc_sat};
        mag         = acc_neg ? (~acc_sat_ext + 1'b1) : acc_sat_ext;
        quot        = mag >> div_shift_reg;
        room        = (pending_reg < pending_max_reg) ? (pending_max_reg - pending_reg)
                                                      : '0;
        if ((|quot[ACC_EXT_W-1:COUNT_W]) || (quot[COUNT_W-1:0] > room)) begin
            n_clicks = room;
        end else begin
            n_clicks = quot[COUNT_W-1:0];
        end
        step    = {{(ACC_EXT_W-COUNT_W){1'b0}}, n_clicks} << div_shift_reg;
        acc_adj = acc_neg ? (acc_sat_ext + step) : (acc_sat_ext - step);
    end

    always_comb begin
        acc_next       = acc_reg;
        pending_next   = pending_reg;
        hold_next      = hold_reg;
        out_click_next = 1'b0;
        case (in_opcode_reg)
            OP_SCROLL: begin
                if (enable_reg) begin
                    acc_next     = acc_adj[ACC_WIDTH-1:0];
                    pending_next = pending_reg + n_clicks;
                    if (n_clicks != '0) begin
                        hold_next = hold_reload_reg;
                    end
                end
            end
            OP_TICK: begin
                if (enable_reg && (pending_reg != '0)) begin
                    if (hold_reg != '0) begin
                        if (in_elapsed_reg >= TICK_MIN_US) begin
                            hold_next = hold_reg - 1'b1;
                        end
                    end else if (scroll_to_click_reg) begin
                        pending_next   = pending_reg - 1'b1;
                        hold_next      = hold_reload_reg;
                        out_click_next = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                acc_next     = '0;
                pending_next = '0;
                hold_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            pending_reg   <= '0;
            hold_reg      <= '0;
        end else if (adv) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                acc_reg     <= acc_next;
                pending_reg <= pending_next;
                hold_reg    <= hold_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid_reg) begin
            out_click_reg <= out_click_next;
        end
    end

    // A result only appears after a transaction sat in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a transaction in the input register");

    // A released click always leaves a freshly reloaded hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_click_reg) |-> (hold_reg == hold_reload_reg))
        else $error("click released without reloading the hold counter");

    // A clear transaction zeroes the accumulator, pending count and hold counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_valid_reg && (in_opcode_reg == OP_CLEAR))
        |=> ((acc_reg == '0) && (pending_reg == '0) && (hold_reg == '0)))
        else $error("clear transaction left state behind");

    // A scroll never lifts the pending count past the cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_valid_reg && (in_opcode_reg == OP_SCROLL)
         && (pending_reg <= pending_max_reg))
        |=> (pending_reg <= $past(pending_max_reg)))
        else $error("pending count exceeded its cap after a scroll");

endmodule
